// ===== rtl/tbmr_pkg.sv =====
// ----------------------------------------------------------------------------
// tbmr_pkg
// Types and constants for the time-bounded least-risk path block.
// ----------------------------------------------------------------------------
package tbmr_pkg;

	localparam int RISK_W      = 24;
	localparam int EDGE_RISK_W = 16;
	localparam int TIME_W      = 8;

	localparam logic [RISK_W-1:0] RISK_SAT = {RISK_W{1'b1}};

	localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [1:0] REG_TIME_BUDGET = 2'd1;

	typedef struct packed {
		logic [TIME_W-1:0]      ttime;
		logic [EDGE_RISK_W-1:0] risk;
	} edge_t;

	typedef struct packed {
		logic              ok;
		logic [RISK_W-1:0] risk;
		logic [TIME_W-1:0] ptime;
	} dp_entry_t;

endpackage

// ===== rtl/tbmr_ram.sv =====
// ----------------------------------------------------------------------------
// tbmr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tbmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/time_bounded_min_risk_path.sv =====
// ----------------------------------------------------------------------------
// time_bounded_min_risk_path
// Loads an edge time/risk matrix and finds the least-risk path from node 0 to
// the last node within a time budget by a table sweep over (node, time left).
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_axis   | in        | tvalid/tready, tlast    | tdata: from, to, time, risk
//  m_axis   | out       | tvalid/tready           | tdata: reachable, risk, time
//  cfg      | in        | cfg_we                  | cfg_index, cfg_data
//
// Matrix words are taken while the block is idle. A word with tlast starts the
// sweep over (budget+1)*N cells (N nodes); destination and zero-time cells are
// written directly, any other cell takes one edge-RAM read per successor and a
// table-RAM read for each successor whose time fits; then the result is read
// and posted. The result waits in an output register; a further matrix word is
// taken meanwhile, the next sweep waits to post until it drains.
// Reset clears control state only; the RAMs hold no reset value.
// ----------------------------------------------------------------------------
module time_bounded_min_risk_path
	import tbmr_pkg::*;
#(
	parameter int MAX_NODES = 128,
	parameter int MAX_TIME  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // from_node[6:0], to_node[13:7],
	                                   // travel_time[21:14], edge_risk[37:22]
	input  logic        s_axis_tlast,  // last_entry
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // reachable[0], min_risk[24:1],
	                                   // path_time[32:25]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int TW = $clog2(MAX_TIME);

	typedef enum logic [2:0] {
		S_IDLE, S_CELL, S_ERD, S_EDATA, S_DDATA, S_WR, S_FIN_RD, S_FIN
	} state_t;

	state_t            state_q;
	logic [7:0]        node_count_q, time_budget_q;
	logic [NW-1:0]     v_q, s_q, nm1_q;
	logic [TW-1:0]     r_q, budget_q;
	logic [TIME_W-1:0] et_q;
	logic              found_q;
	logic [RISK_W-1:0] brisk_q;
	logic [TIME_W-1:0] btime_q;
	logic              out_valid_q;
	dp_entry_t         out_q;

	logic [6:0]        in_from, in_to;
	edge_t             in_edge;
	logic              in_acc, in_store;
	logic [8:0]        nm1_calc;
	logic [TW-1:0]     budget_calc;

	edge_t             edge_rd;
	logic [TIME_W-1:0] et;
	logic              et_fits;
	dp_entry_t         dp_rd, dp_wdata;
	logic              dp_we;
	logic [NW+TW-1:0]  dp_raddr;
	logic [RISK_W:0]   sum_full;
	logic [RISK_W-1:0] sum;

	assign in_from       = s_axis_tdata[6:0];
	assign in_to         = s_axis_tdata[13:7];
	assign in_edge.ttime = s_axis_tdata[21:14];
	assign in_edge.risk  = s_axis_tdata[37:22];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_store      = in_acc && (9'(in_from) < 9'(MAX_NODES))
	                              && (9'(in_to) < 9'(MAX_NODES));

	always_comb begin
		if (node_count_q < 8'd2) begin
			nm1_calc = 9'd1;
		end else if ({1'b0, node_count_q} > 9'(MAX_NODES)) begin
			nm1_calc = 9'(MAX_NODES - 1);
		end else begin
			nm1_calc = {1'b0, node_count_q} - 9'd1;
		end
		if ({3'b0, time_budget_q} > 11'(MAX_TIME - 1)) begin
			budget_calc = TW'(MAX_TIME - 1);
		end else begin
			budget_calc = TW'(time_budget_q);
		end
	end

	tbmr_ram #(.WIDTH($bits(edge_t)), .DEPTH(2 ** (2 * NW))) u_edge_ram (
		.clk   (clk),
		.we    (in_store),
		.waddr ({NW'(in_from), NW'(in_to)}),
		.wdata (in_edge),
		.raddr ({v_q, s_q}),
		.rdata (edge_rd)
	);

	// zero travel time counts as one
	assign et      = (edge_rd.ttime == '0) ? TIME_W'(1) : edge_rd.ttime;
	assign et_fits = (s_q != v_q) && (11'(et) <= 11'(r_q));

	always_comb begin
		dp_raddr = {NW'(0), budget_q};
		if (state_q == S_EDATA) begin
			dp_raddr = {s_q, r_q - TW'(et)};
		end
	end

	always_comb begin
		dp_we    = 1'b0;
		dp_wdata = '{ok: found_q, risk: brisk_q, ptime: btime_q};
		if (state_q == S_CELL && v_q == nm1_q) begin
			dp_we    = 1'b1;
			dp_wdata = '{ok: 1'b1, risk: '0, ptime: '0};
		end else if (state_q == S_CELL && r_q == '0) begin
			dp_we    = 1'b1;
			dp_wdata = '{ok: 1'b0, risk: '0, ptime: '0};
		end else if (state_q == S_WR) begin
			dp_we = 1'b1;
		end
	end

	tbmr_ram #(.WIDTH($bits(dp_entry_t)), .DEPTH(2 ** (NW + TW))) u_dp_ram (
		.clk   (clk),
		.we    (dp_we),
		.waddr ({v_q, r_q}),
		.wdata (dp_wdata),
		.raddr (dp_raddr),
		.rdata (dp_rd)
	);

	assign sum_full = {1'b0, dp_rd.risk} + (RISK_W + 1)'(edge_rd.risk);
	assign sum      = sum_full[RISK_W] ? RISK_SAT : sum_full[RISK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			node_count_q  <= 8'd2;
			time_budget_q <= 8'd1;
			out_valid_q   <= 1'b0;
			v_q           <= '0;
			s_q           <= '0;
			r_q           <= '0;
			nm1_q         <= '0;
			budget_q      <= '0;
			found_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NODE_COUNT:  node_count_q  <= cfg_data;
					REG_TIME_BUDGET: time_budget_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_FIN && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && s_axis_tlast) begin
						nm1_q    <= NW'(nm1_calc);
						budget_q <= budget_calc;
						v_q      <= '0;
						s_q      <= '0;
						r_q      <= '0;
						state_q  <= S_CELL;
					end
				end
				S_CELL: begin
					found_q <= 1'b0;
					brisk_q <= '0;
					btime_q <= '0;
					s_q     <= '0;
					if (v_q == nm1_q || r_q == '0) begin
						// cell written this cycle; advance
						if (v_q == nm1_q) begin
							v_q <= '0;
							if (r_q == budget_q) begin
								state_q <= S_FIN_RD;
							end else begin
								r_q <= r_q + TW'(1);
							end
						end else begin
							v_q <= v_q + NW'(1);
						end
					end else begin
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_EDATA;
				S_EDATA: begin
					et_q <= et;
					if (et_fits) begin
						state_q <= S_DDATA;
					end else if (s_q == nm1_q) begin
						state_q <= S_WR;
					end else begin
						s_q     <= s_q + NW'(1);
						state_q <= S_ERD;
					end
				end
				S_DDATA: begin
					if (dp_rd.ok && (!found_q || sum < brisk_q)) begin
						found_q <= 1'b1;
						brisk_q <= sum;
						btime_q <= et_q + dp_rd.ptime;
					end
					if (s_q == nm1_q) begin
						state_q <= S_WR;
					end else begin
						s_q     <= s_q + NW'(1);
						state_q <= S_ERD;
					end
				end
				S_WR: begin
					if (v_q == nm1_q) begin
						v_q <= '0;
						if (r_q != budget_q) begin
							r_q <= r_q + TW'(1);
						end
					end else begin
						v_q <= v_q + NW'(1);
					end
					state_q <= (v_q == nm1_q && r_q == budget_q) ? S_FIN_RD : S_CELL;
				end
				S_FIN_RD: state_q <= S_FIN;
				S_FIN: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_q   <= dp_rd.ok ? dp_rd : '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_q.ptime, out_q.risk, out_q.ok};

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !dp_we)
		else $error("table written while idle");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_q == S_CELL))
		else $error("last word did not start sweep");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (s_q <= nm1_q && v_q <= nm1_q && r_q <= budget_q))
		else $error("sweep index out of range");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:1] == '0))
		else $error("unreachable result carries nonzero fields");

endmodule

// ===== dv/tb_time_bounded_min_risk_path.sv =====
// ----------------------------------------------------------------------------
// tb_time_bounded_min_risk_path
// Self-checking bench: loads edge matrices word by word, runs sweeps over a
// range of node counts and time budgets, and checks every result word against
// a local (node, time left) table predictor. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_time_bounded_min_risk_path;
	import tbmr_pkg::*;

	localparam int NODES_MAX  = 128;
	localparam int TIME_MAX   = 256;
	localparam int DRAIN_CYC  = 20;
	localparam int STALL_LIM  = 400000;

	typedef struct {
		logic              reach;
		logic [RISK_W-1:0] risk;
		logic [TIME_W-1:0] ptime;
	} path_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	// matrix and configuration as the block should hold them
	logic [7:0]       time_mem [0:NODES_MAX*NODES_MAX-1];
	logic [15:0]      risk_mem [0:NODES_MAX*NODES_MAX-1];
	int unsigned      tbl_risk [0:NODES_MAX-1][0:TIME_MAX-1];
	int unsigned      tbl_time [0:NODES_MAX-1][0:TIME_MAX-1];
	bit               tbl_ok   [0:NODES_MAX-1][0:TIME_MAX-1];
	logic [7:0]       node_reg;
	logic [7:0]       budget_reg;

	path_res_t        path_q[$];
	int               errors;
	int               words_sent;
	int               sweeps_done;
	int               results_seen;
	int               idle_cyc;
	bit               idling_on;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	time_bounded_min_risk_path DUT (.*);

	// least-risk path table over (node, time left), node 0 at full budget
	function automatic path_res_t solve_path();
		int unsigned n, b, dest, et, sum, brisk, btime;
		bit found;
		path_res_t res;
		n = (node_reg < 2) ? 2 : ((node_reg > NODES_MAX) ? NODES_MAX : node_reg);
		b = (budget_reg > TIME_MAX-1) ? TIME_MAX-1 : budget_reg;
		dest = n - 1;
		for (int r = 0; r <= b; r++) begin
			for (int v = 0; v < n; v++) begin
				found = 0;
				brisk = 0;
				btime = 0;
				if (v != dest && r > 0) begin
					for (int s = 0; s < n; s++) begin
						if (s == v) continue;
						et = time_mem[v*NODES_MAX+s];
						if (et == 0) et = 1;
						if (et > r) continue;
						if (!tbl_ok[s][r-et]) continue;
						sum = tbl_risk[s][r-et] + risk_mem[v*NODES_MAX+s];
						if (sum > RISK_SAT) sum = RISK_SAT;
						if (!found || sum < brisk) begin
							found = 1;
							brisk = sum;
							btime = et + tbl_time[s][r-et];
						end
					end
				end
				tbl_ok[v][r]   = (v == dest) ? 1'b1 : found;
				tbl_risk[v][r] = (v == dest) ? 0 : brisk;
				tbl_time[v][r] = (v == dest) ? 0 : btime;
			end
		end
		res.reach = tbl_ok[0][b];
		res.risk  = tbl_ok[0][b] ? tbl_risk[0][b][RISK_W-1:0] : '0;
		res.ptime = tbl_ok[0][b] ? tbl_time[0][b][TIME_W-1:0] : '0;
		return res;
	endfunction

	task automatic send_word(input int from, input int to, input int ttime,
	                         input int risk, input bit last);
		int gap;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b0, risk[15:0], ttime[7:0], to[6:0], from[6:0]};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		time_mem[from*NODES_MAX+to] = ttime[7:0];
		risk_mem[from*NODES_MAX+to] = risk[15:0];
		if (last) begin
			path_q.push_back(solve_path());
			sweeps_done++;
		end
	endtask

	// lower tvalid, wait for every pending result, then let the block settle
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (path_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_NODE_COUNT) node_reg = val;
		else if (idx == REG_TIME_BUDGET) budget_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_time();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return $urandom_range(0, 255);
			2:       return 255;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int pick_risk();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 65535;
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	// full N x N load with random content and, with noise set, stray words, then one sweep
	task automatic run_graph(input int n, input int b, input bit noise);
		int cnt;
		write_reg(REG_NODE_COUNT, n[7:0]);
		write_reg(REG_TIME_BUDGET, b[7:0]);
		cnt = 0;
		for (int f = 0; f < n; f++) begin
			for (int t = 0; t < n; t++) begin
				cnt++;
				if (noise && $urandom_range(0, 9) == 0)
					send_word($urandom_range(0, 127), $urandom_range(0, 127),
					          $urandom_range(0, 255), $urandom_range(0, 65535), 1'b0);
				send_word(f, t, pick_time(), pick_risk(), cnt == n*n);
			end
		end
		drain();
	endtask

	task automatic test_minimal_graph();
		// reset settings: two nodes, budget one; zero time counts as one
		send_word(0, 0, 0, 0, 1'b0);
		send_word(1, 0, 9, 3, 1'b0);
		send_word(1, 1, 0, 0, 1'b0);
		send_word(0, 1, 0, 65535, 1'b1);
		drain();
	endtask

	task automatic test_budget_edges();
		write_reg(REG_TIME_BUDGET, 8'd0);
		send_word(0, 1, 1, 7, 1'b1);
		drain();
		write_reg(REG_TIME_BUDGET, 8'd1);
		send_word(0, 1, 2, 7, 1'b1);
		drain();
		write_reg(REG_TIME_BUDGET, 8'd255);
		send_word(0, 1, 255, 65535, 1'b1);
		drain();
	endtask

	task automatic test_field_extremes();
		// stray words at the top indexes, stored but outside the graph
		send_word(127, 127, 255, 65535, 1'b0);
		send_word(127, 0, 170, 43690, 1'b0);
		send_word(0, 127, 85, 21845, 1'b0);
		write_reg(2'd2, 8'd77);
		write_reg(2'd3, 8'd1);
		write_reg(REG_NODE_COUNT, 8'd255);
		write_reg(REG_NODE_COUNT, 8'd0);
		send_word(0, 1, 3, 12, 1'b1);
		drain();
	endtask

	task automatic test_ties();
		// equal risk through two relays: the lower index must win
		write_reg(REG_NODE_COUNT, 8'd4);
		write_reg(REG_TIME_BUDGET, 8'd6);
		for (int f = 0; f < 4; f++)
			for (int t = 0; t < 4; t++)
				send_word(f, t, (f == 0 && t == 3) ? 200 : (t == 2 ? 3 : 1),
				          (f == 0 && t == 3) ? 0 : 5, f == 3 && t == 3);
		drain();
	endtask

	task automatic test_random_graphs();
		while (words_sent < 1000) begin
			if ($urandom_range(0, 15) == 0)
				run_graph($urandom_range(2, 12), $urandom_range(0, 255), 1'b1);
			else
				run_graph($urandom_range(2, 7), $urandom_range(0, 24), 1'b1);
		end
		run_graph(16, 60, 1'b0);
		run_graph(3, 255, 1'b1);
	endtask

	task automatic test_full_rate();
		idling_on = 0;
		while (words_sent < 1450)
			run_graph($urandom_range(2, 6), $urandom_range(1, 16), 1'b1);
	endtask

	// receiver stalls in random bursts
	int stall_left;
	always @(negedge clk) begin
		if (!idling_on) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left    <= $urandom_range(1, 14) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		path_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (path_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, m_axis_tdata);
			end else begin
				want = path_q.pop_front();
				if (m_axis_tdata[0] !== want.reach) begin
					errors++;
					$display("%0t: reachable exp %0d got %0d", $time, want.reach,
					         m_axis_tdata[0]);
				end
				if (m_axis_tdata[24:1] !== want.risk) begin
					errors++;
					$display("%0t: min_risk exp %0d got %0d", $time, want.risk,
					         m_axis_tdata[24:1]);
				end
				if (m_axis_tdata[32:25] !== want.ptime) begin
					errors++;
					$display("%0t: path_time exp %0d got %0d", $time, want.ptime,
					         m_axis_tdata[32:25]);
				end
			end
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= STALL_LIM) begin
			$display("watchdog expired at %0t", $time);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		node_reg      = 8'd2;
		budget_reg    = 8'd1;
		errors        = 0;
		words_sent    = 0;
		sweeps_done   = 0;
		results_seen  = 0;
		idle_cyc      = 0;
		stall_left    = 0;
		idling_on     = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_minimal_graph();
		test_budget_edges();
		test_field_extremes();
		test_ties();
		test_random_graphs();
		test_full_rate();

		drain();
		$display("Loaded %0d matrix words, ran %0d sweeps, checked %0d results.",
		         words_sent, sweeps_done, results_seen);
		if (errors == 0 && path_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== time_bounded_min_risk_path.f =====
rtl/tbmr_pkg.sv
rtl/tbmr_ram.sv
rtl/time_bounded_min_risk_path.sv
dv/tb_time_bounded_min_risk_path.sv
